[design/lmce_pkg.sv]
package lmce_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 12;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 10;
    localparam int SUM_W   = 18;
    localparam int DEN_W   = 18;
    localparam int DIV_W   = 32;
    localparam int DCNT_W  = 6;

    localparam logic [IDX_W-1:0] CFG_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] CFG_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] CFG_BLOCK  = 3'd2;
    localparam logic [IDX_W-1:0] CFG_GAIN   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_TARGET = 3'd4;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_SAT = 2'd1;
    localparam logic [1:0] ST_OUT = 2'd2;

    typedef struct packed {
        logic start;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[design/lmce_mem.sv]
module lmce_mem #(
    parameter int AW = 16
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [AW-1:0]             i_waddr,
    input  logic [lmce_pkg::PIX_W-1:0] i_wdata,
    input  logic [AW-1:0]             i_raddr,
    output logic [lmce_pkg::PIX_W-1:0] o_rdata
);
    import lmce_pkg::*;

    logic [PIX_W-1:0] mem [2**AW];
    logic [PIX_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[design/lmce_div.sv]
module lmce_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lmce_pkg::t_div_ctrl        i_ctrl,
    input  logic [lmce_pkg::DIV_W-1:0] i_dividend,
    input  logic [lmce_pkg::DEN_W-1:0] i_divisor,
    output lmce_pkg::t_div_stat        o_stat,
    output logic [lmce_pkg::DIV_W-1:0] o_quot,
    output logic [lmce_pkg::DEN_W-1:0] o_rem
);
    import lmce_pkg::*;

    logic [DCNT_W-1:0] r_cnt;
    logic              r_done;
    logic [DIV_W-1:0]  r_q;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_d;
    logic [DEN_W:0]    trial;

    // one quotient bit per cycle, restoring
    assign trial = {r_rem, r_q[DIV_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_cnt <= DCNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_cnt != '0) begin
            if (trial >= {1'b0, r_d}) begin
                r_rem <= DEN_W'(trial - {1'b0, r_d});
                r_q   <= {r_q[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DEN_W-1:0];
                r_q   <= {r_q[DIV_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = (r_cnt != '0);
    assign o_stat.done = r_done;
    assign o_quot      = r_q;
    assign o_rem       = r_rem;
endmodule

[design/local_mean_contrast_enhance.sv]
// channel  direction  handshake                    payload
// in       input      i_in_valid / o_in_ready      i_req_type i_col i_row i_pixel
// out      output     o_out_valid / i_out_ready    o_out_pixel o_out_col o_out_row o_status
// cfg      input      i_cfg_we (no wait)           i_cfg_addr i_cfg_data
//
// a load item writes its pixel to the frame store at acceptance, if it lies inside the frame
// an inside-frame query does one frame store read per window pixel
// (the frame store has a single read port), then multiplies and a serial divide
// synchronous active-low reset; the frame store is not cleared and needs no sweep
// a finished result waits in the output register; new items are still taken meanwhile
module local_mean_contrast_enhance #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_BLOCK  = 31
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [lmce_pkg::IDX_W-1:0] i_cfg_addr,
    input  logic [lmce_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_req_type,
    input  logic [7:0]                 i_col,
    input  logic [7:0]                 i_row,
    input  logic [7:0]                 i_pixel,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [7:0]                 o_out_pixel,
    output logic [7:0]                 o_out_col,
    output logic [7:0]                 o_out_row,
    output logic [1:0]                 o_status
);
    import lmce_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int AW = CW + RW;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_SUM  = 9'b000000010,
        S_PIX  = 9'b000000100,
        S_PIXW = 9'b000001000,
        S_MUL1 = 9'b000010000,
        S_MUL2 = 9'b000100000,
        S_NUM  = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    // configuration registers
    logic [8:0]  r_width, r_height;
    logic [4:0]  r_block;
    logic [11:0] r_gain;
    logic [7:0]  r_target;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
            r_block  <= 5'd15;
            r_gain   <= 12'd256;
            r_target <= 8'd128;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_WIDTH:  r_width  <= i_cfg_data[8:0];
                CFG_HEIGHT: r_height <= i_cfg_data[8:0];
                CFG_BLOCK:  r_block  <= i_cfg_data[4:0];
                CFG_GAIN:   r_gain   <= i_cfg_data[11:0];
                CFG_TARGET: r_target <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective sizes: zero acts as one, above the maximum acts as the maximum
    logic [8:0] w_eff, h_eff;
    logic [4:0] b_eff;
    always_comb begin
        w_eff = r_width;
        if (r_width == '0) w_eff = 9'd1;
        else if (32'(r_width) > MAX_WIDTH) w_eff = 9'(MAX_WIDTH);
        h_eff = r_height;
        if (r_height == '0) h_eff = 9'd1;
        else if (32'(r_height) > MAX_HEIGHT) h_eff = 9'(MAX_HEIGHT);
        b_eff = r_block;
        if (r_block == '0) b_eff = 5'd1;
        else if (32'(r_block) > MAX_BLOCK) b_eff = 5'(MAX_BLOCK);
    end

    // window origin and size at acceptance
    logic [3:0] half;
    logic [7:0] x0, y0;
    logic [4:0] ww, wh;
    logic       in_frame;
    always_comb begin
        half = b_eff[4:1];
        x0 = (i_col >= {4'd0, half}) ? i_col - {4'd0, half} : 8'd0;
        y0 = (i_row >= {4'd0, half}) ? i_row - {4'd0, half} : 8'd0;
        ww = b_eff;
        if ({1'b0, x0} + {4'd0, b_eff} > w_eff) ww = 5'(w_eff - {1'b0, x0});
        wh = b_eff;
        if ({1'b0, y0} + {4'd0, b_eff} > h_eff) wh = 5'(h_eff - {1'b0, y0});
        in_frame = ({1'b0, i_col} < w_eff) && ({1'b0, i_row} < h_eff);
    end

    t_state r_state;
    logic   accept;
    assign o_in_ready = i_rst_n && (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    logic [7:0]       r_col, r_row, r_x0, r_y0;
    logic [4:0]       r_ww, r_wh, r_xi, r_yi;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_sum;
    logic             r_acc;
    logic [7:0]       r_p;
    logic [SUM_W-1:0] r_pc, r_tc;
    logic signed [31:0] r_prod;
    logic [7:0]       r_res;
    logic [1:0]       r_res_st;

    // frame store
    logic            mem_we;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_rdata;
    logic [8:0]      rd_x, rd_y;

    assign mem_we    = accept && (i_req_type == REQ_LOAD) && in_frame;
    assign mem_waddr = {RW'(i_row), CW'(i_col)};
    always_comb begin
        rd_x = {1'b0, r_x0} + {4'd0, r_xi};
        rd_y = {1'b0, r_y0} + {4'd0, r_yi};
        if (r_state == S_PIX) begin
            rd_x = {1'b0, r_col};
            rd_y = {1'b0, r_row};
        end
    end
    assign mem_raddr = {RW'(rd_y), CW'(rd_x)};

    lmce_mem #(.AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_pixel),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // serial divider
    t_div_ctrl          div_ctrl;
    t_div_stat          div_stat;
    logic [DIV_W-1:0]   div_q;
    logic [DEN_W-1:0]   div_rem, den;
    logic signed [33:0] num_plus;
    assign den = {r_cnt, 8'd0};
    // numerator plus one denominator, so a value not below -1 stays non-negative
    assign num_plus = 34'(r_prod) + $signed({8'd0, r_tc, 8'd0})
                    + $signed({16'd0, den});
    assign div_ctrl.start = (r_state == S_NUM) && !num_plus[33];

    lmce_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (div_ctrl),
        .i_dividend (DIV_W'(num_plus)),
        .i_divisor  (den),
        .o_stat     (div_stat),
        .o_quot     (div_q),
        .o_rem      (div_rem)
    );

    // rounding of (quotient + 1), remainder: ties go to even on the true quotient
    logic [DEN_W:0] rem2;
    logic           inc;
    logic [DIV_W:0] qr;
    always_comb begin
        rem2 = {div_rem, 1'b0};
        inc  = (rem2 > {1'b0, den}) || ((rem2 == {1'b0, den}) && !div_q[0]);
        qr   = {1'b0, div_q} + {{DIV_W{1'b0}}, inc};
    end

    logic out_load;
    assign out_load = (r_state == S_DONE) && (!o_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_acc <= 1'b0;
            if (out_load) o_out_valid <= 1'b1;
            else if (i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_req_type == REQ_QUERY)) begin
                        r_state <= in_frame ? S_SUM : S_DONE;
                    end
                end
                S_SUM: begin
                    r_acc <= 1'b1;
                    if ((r_xi == r_ww - 1'b1) && (r_yi == r_wh - 1'b1)) r_state <= S_PIX;
                end
                S_PIX:  r_state <= S_PIXW;
                S_PIXW: r_state <= S_MUL1;
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_NUM;
                S_NUM:  r_state <= num_plus[33] ? S_DONE : S_DIV;
                S_DIV:  if (div_stat.done) r_state <= S_DONE;
                S_DONE: if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_acc) r_sum <= r_sum + {{(SUM_W-8){1'b0}}, mem_rdata};
        case (r_state)
            S_IDLE: begin
                r_col    <= i_col;
                r_row    <= i_row;
                r_x0     <= x0;
                r_y0     <= y0;
                r_ww     <= ww;
                r_wh     <= wh;
                r_xi     <= '0;
                r_yi     <= '0;
                r_sum    <= '0;
                r_cnt    <= CNT_W'(ww * wh);
                r_res    <= '0;
                r_res_st <= ST_OUT;
            end
            S_SUM: begin
                if (r_xi == r_ww - 1'b1) begin
                    r_xi <= '0;
                    r_yi <= r_yi + 1'b1;
                end else begin
                    r_xi <= r_xi + 1'b1;
                end
            end
            S_PIXW: r_p <= mem_rdata;
            S_MUL1: begin
                r_pc <= SUM_W'(r_p * r_cnt);
                r_tc <= SUM_W'(r_target * r_cnt);
            end
            S_MUL2: begin
                r_prod <= $signed({1'b0, r_gain})
                        * ($signed({1'b0, r_pc}) - $signed({1'b0, r_sum}));
            end
            S_NUM: begin
                // below -1 saturates low without dividing
                r_res    <= '0;
                r_res_st <= ST_SAT;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    if (qr == '0) begin
                        r_res    <= '0;
                        r_res_st <= ST_SAT;
                    end else if (qr > (DIV_W+1)'(256)) begin
                        r_res    <= 8'd255;
                        r_res_st <= ST_SAT;
                    end else begin
                        r_res    <= 8'(qr - 1'b1);
                        r_res_st <= ST_OK;
                    end
                end
            end
            default: ;
        endcase
    end

    // output register, loaded when the previous result has moved on
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_out_pixel <= r_res;
            o_out_col   <= r_col;
            o_out_row   <= r_row;
            o_status    <= r_res_st;
        end
    end
endmodule
